// File: hw/rtl/i2cmbc_pkg.sv
// Shared types and constants for the I2C master byte controller.
// No dependencies; imported by i2cmbc_step and i2c_master_byte_controller.

package i2cmbc_pkg;

	localparam int CNT_W_DEF = 10;          // default wait counter width
	localparam int HP_W      = 10;          // half period register width
	localparam int PADDR_W   = 3;           // byte address over 32-bit registers
	localparam int PDATA_W   = 32;

	localparam logic [HP_W-1:0] HALF_PERIOD_RST = HP_W'(10);
	localparam logic [3:0]      BITS_PER_BYTE   = 4'd8;

	// register index (paddr above the byte lanes)
	localparam logic [PADDR_W-3:0] REG_HALF_PERIOD = '0;

	// action codes
	localparam logic [2:0] ACT_TICK  = 3'd0;
	localparam logic [2:0] ACT_START = 3'd1;
	localparam logic [2:0] ACT_STOP  = 3'd2;
	localparam logic [2:0] ACT_WRITE = 3'd3;
	localparam logic [2:0] ACT_READ  = 3'd4;

	typedef enum logic [11:0] {
		PH_IDLE      = 12'h001,
		PH_START_A   = 12'h002,
		PH_START_B   = 12'h004,
		PH_START_C   = 12'h008,
		PH_STOP_A    = 12'h010,
		PH_STOP_B    = 12'h020,
		PH_STOP_C    = 12'h040,
		PH_WBIT_HIGH = 12'h080,
		PH_WBIT_LOW  = 12'h100,
		PH_RBIT_HIGH = 12'h200,
		PH_RBIT_LOW  = 12'h400,
		PH_READ_TAIL = 12'h800
	} phase_t;

	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_STOP  = 2'd1,
		KIND_WRITE = 2'd2,
		KIND_READ  = 2'd3
	} kind_t;

	// controller state apart from the wait counter, whose width is a parameter
	typedef struct packed {
		phase_t     phase;
		logic [3:0] bit_index;
		logic [7:0] shift_reg;
		kind_t      kind;
		logic       scl_drive;
		logic       sda_drive;
		logic       ack_bit;
		logic       ack_to_send;
		logic [7:0] read_latch;
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic rejected;
	} flags_t;

	localparam state_t ST_RESET = '{
		phase:       PH_IDLE,
		bit_index:   4'd0,
		shift_reg:   8'd0,
		kind:        KIND_START,
		scl_drive:   1'b0,
		sda_drive:   1'b0,
		ack_bit:     1'b0,
		ack_to_send: 1'b0,
		read_latch:  8'd0
	};

endpackage

// File: hw/rtl/i2cmbc_step.sv
// Next-state logic of the I2C master: one word in, new state and status out.
// Depends on i2cmbc_pkg.

module i2cmbc_step import i2cmbc_pkg::*; #(
	parameter int COUNTER_WIDTH = CNT_W_DEF
) (
	input  state_t                   st,
	input  logic [COUNTER_WIDTH-1:0] wait_cnt,
	input  logic [HP_W-1:0]          half_period,
	input  logic [2:0]               action,
	input  logic [7:0]               byte_out,
	input  logic                     send_ack,
	input  logic                     sda_in,
	output state_t                   st_nxt,
	output logic [COUNTER_WIDTH-1:0] wait_nxt,
	output flags_t                   flags
);

	localparam int LW = (COUNTER_WIDTH > HP_W) ? COUNTER_WIDTH : HP_W;

	logic [LW-1:0]            hp_ext;
	logic [LW-1:0]            cnt_max;
	logic [COUNTER_WIDTH-1:0] load_val;
	logic                     busy;
	logic                     ent;
	logic                     fin;
	logic                     rej;
	phase_t                   ent_ph;
	state_t                   s;
	logic [COUNTER_WIDTH-1:0] w;

	// bit driven in a write-bit phase: data MSB, or the ACK/NACK bit of a read
	function automatic logic cur_wbit(state_t x);
		return (x.kind == KIND_READ) ? ~x.ack_to_send : x.shift_reg[7];
	endfunction

	// zero counts as one, above the counter range saturates
	assign hp_ext  = LW'(half_period);
	assign cnt_max = LW'({COUNTER_WIDTH{1'b1}});
	always_comb begin
		if (half_period == '0)
			load_val = COUNTER_WIDTH'(1);
		else if (hp_ext > cnt_max)
			load_val = cnt_max[COUNTER_WIDTH-1:0];
		else
			load_val = hp_ext[COUNTER_WIDTH-1:0];
	end

	assign busy = (st.phase != PH_IDLE);

	always_comb begin
		s      = st;
		w      = wait_cnt;
		ent    = 1'b0;
		fin    = 1'b0;
		rej    = 1'b0;
		ent_ph = PH_IDLE;

		case (action)
			ACT_TICK: begin
				if (busy) begin
					if (wait_cnt > COUNTER_WIDTH'(1)) begin
						w = wait_cnt - COUNTER_WIDTH'(1);
					end else begin
						case (st.phase)
							PH_START_A: begin
								ent    = 1'b1;
								ent_ph = PH_START_B;
							end
							PH_START_B: begin
								ent    = 1'b1;
								ent_ph = PH_START_C;
							end
							PH_STOP_A: begin
								ent    = 1'b1;
								ent_ph = PH_STOP_B;
							end
							PH_STOP_B: begin
								ent    = 1'b1;
								ent_ph = PH_STOP_C;
							end
							PH_WBIT_HIGH: begin
								ent    = 1'b1;
								ent_ph = PH_WBIT_LOW;
							end
							PH_WBIT_LOW: begin
								// a sent 1 is followed by SDA pulled low again
								if (cur_wbit(st))
									s.sda_drive = 1'b1;
								ent = 1'b1;
								if (st.kind == KIND_READ) begin
									ent_ph = PH_READ_TAIL;
								end else begin
									s.shift_reg = {st.shift_reg[6:0], 1'b0};
									s.bit_index = st.bit_index + 4'd1;
									ent_ph = (s.bit_index < BITS_PER_BYTE) ?
										PH_WBIT_HIGH : PH_RBIT_HIGH;
								end
							end
							PH_RBIT_HIGH: begin
								if (st.kind == KIND_READ)
									s.shift_reg = {st.shift_reg[6:0], sda_in};
								else
									s.ack_bit = sda_in;
								ent    = 1'b1;
								ent_ph = PH_RBIT_LOW;
							end
							PH_RBIT_LOW: begin
								if (st.kind == KIND_READ) begin
									s.bit_index = st.bit_index + 4'd1;
									ent    = 1'b1;
									ent_ph = (s.bit_index < BITS_PER_BYTE) ?
										PH_RBIT_HIGH : PH_WBIT_HIGH;
								end else begin
									fin = 1'b1;
								end
							end
							PH_READ_TAIL: begin
								s.read_latch = st.shift_reg;
								fin = 1'b1;
							end
							default: begin
								fin = 1'b1;
							end
						endcase
					end
				end
			end
			ACT_START, ACT_STOP, ACT_WRITE, ACT_READ: begin
				if (busy) begin
					rej = 1'b1;
				end else begin
					s.bit_index = 4'd0;
					ent = 1'b1;
					case (action)
						ACT_START: begin
							s.kind = KIND_START;
							ent_ph = PH_START_A;
						end
						ACT_STOP: begin
							s.kind = KIND_STOP;
							ent_ph = PH_STOP_A;
						end
						ACT_WRITE: begin
							s.kind      = KIND_WRITE;
							s.shift_reg = byte_out;
							ent_ph      = PH_WBIT_HIGH;
						end
						default: begin
							s.kind        = KIND_READ;
							s.shift_reg   = 8'd0;
							s.ack_to_send = send_ack;
							ent_ph        = PH_RBIT_HIGH;
						end
					endcase
				end
			end
			default: ;
		endcase

		// pin change of the phase being entered, then reload the wait
		if (ent) begin
			s.phase = ent_ph;
			w       = load_val;
			case (ent_ph)
				PH_START_A: begin
					s.scl_drive = 1'b0;
					s.sda_drive = 1'b0;
				end
				PH_START_B:  s.sda_drive = 1'b1;
				PH_START_C:  s.scl_drive = 1'b1;
				PH_STOP_A: begin
					s.scl_drive = 1'b1;
					s.sda_drive = 1'b1;
				end
				PH_STOP_B:   s.scl_drive = 1'b0;
				PH_STOP_C:   s.sda_drive = 1'b0;
				PH_WBIT_HIGH: begin
					s.sda_drive = ~cur_wbit(s);
					s.scl_drive = 1'b0;
				end
				PH_WBIT_LOW: s.scl_drive = 1'b1;
				PH_RBIT_HIGH: begin
					s.sda_drive = 1'b0;
					s.scl_drive = 1'b0;
				end
				PH_RBIT_LOW: s.scl_drive = 1'b1;
				default: ;
			endcase
		end

		if (fin) begin
			s.phase = PH_IDLE;
			w       = '0;
		end
	end

	assign st_nxt         = s;
	assign wait_nxt       = w;
	assign flags.busy     = (s.phase != PH_IDLE);
	assign flags.done     = fin;
	assign flags.rejected = rej;

endmodule

// File: hw/rtl/i2c_master_byte_controller.sv
// I2C master byte controller: each accepted word passes the input register, then the state
// update into the result register; a stalled output holds both. Throughput one word per clock
// unless the output stalls; the whole state update is one pass of i2cmbc_step.
// Reset: controller state idle, SCL and SDA released, read data and ack cleared, half period 10.
// Depends on i2cmbc_pkg and i2cmbc_step.

module i2c_master_byte_controller import i2cmbc_pkg::*; #(
	parameter int COUNTER_WIDTH = CNT_W_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         action,
	input  logic [7:0]         byte_out,
	input  logic               send_ack,
	input  logic               sda_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               scl_low,
	output logic               sda_low,
	output logic               busy_res,
	output logic               done_res,
	output logic [7:0]         read_data,
	output logic               ack_seen,
	output logic               rejected
);

	logic [HP_W-1:0]          half_period_q;
	logic                     reg_sel;

	logic                     valid_s1;
	logic [2:0]               action_s1;
	logic [7:0]               byte_out_s1;
	logic                     send_ack_s1;
	logic                     sda_in_s1;

	state_t                   st_q;
	logic [COUNTER_WIDTH-1:0] wait_q;
	state_t                   st_nxt;
	logic [COUNTER_WIDTH-1:0] wait_nxt;
	flags_t                   flags;

	logic                     valid_s2;
	state_t                   st_s2;
	flags_t                   flags_s2;

	logic                     adv;

	// config register
	assign pready  = 1'b1;
	assign reg_sel = (paddr[PADDR_W-1:2] == REG_HALF_PERIOD);
	assign prdata  = reg_sel ? PDATA_W'(half_period_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RST;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			half_period_q <= pwdata[HP_W-1:0];
		end
	end

	// output register frees up when empty or taken this cycle
	assign adv      = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			action_s1   <= action;
			byte_out_s1 <= byte_out;
			send_ack_s1 <= send_ack;
			sda_in_s1   <= sda_in;
		end
	end

	i2cmbc_step #(
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_step (
		.st          (st_q),
		.wait_cnt    (wait_q),
		.half_period (half_period_q),
		.action      (action_s1),
		.byte_out    (byte_out_s1),
		.send_ack    (send_ack_s1),
		.sda_in      (sda_in_s1),
		.st_nxt      (st_nxt),
		.wait_nxt    (wait_nxt),
		.flags       (flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_RESET;
			wait_q   <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv)
				valid_s2 <= valid_s1;
			if (valid_s1 && adv) begin
				st_q   <= st_nxt;
				wait_q <= wait_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			st_s2    <= st_nxt;
			flags_s2 <= flags;
		end
	end

	assign out_valid = valid_s2;
	assign scl_low   = st_s2.scl_drive;
	assign sda_low   = st_s2.sda_drive;
	assign busy_res  = flags_s2.busy;
	assign done_res  = flags_s2.done;
	assign read_data = st_s2.read_latch;
	assign ack_seen  = st_s2.ack_bit;
	assign rejected  = flags_s2.rejected;

	// wait counter runs exactly while a command is in progress
	a_wait_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == PH_IDLE) == (wait_q == '0))
		else $error("wait counter out of step with phase");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.bit_index <= BITS_PER_BYTE)
		else $error("bit index past one byte");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && flags_s2.done |-> !flags_s2.busy && !flags_s2.rejected)
		else $error("completion reported while still busy or rejected");

	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && flags_s2.rejected |-> flags_s2.busy)
		else $error("command rejected while idle");

endmodule

// File: dv/i2c_master_byte_controller_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for i2c_master_byte_controller: drives command and tick words,
// predicts pin drive and status for each word, and checks the result stream in order.
// Depends on i2cmbc_pkg and the controller RTL.

module i2c_master_byte_controller_tb;
	import i2cmbc_pkg::*;

	localparam int CYCLE_LIMIT = 400_000;
	localparam int CNT_MAX = (1 << CNT_W_DEF) - 1;
	localparam logic [PADDR_W-3:0] REG_SPARE = 1'b1;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       busy;
		logic       done;
		logic [7:0] rdata;
		logic       ack;
		logic       rej;
	} bus_view_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [2:0]         action = ACT_TICK;
	logic [7:0]         byte_out = '0;
	logic               send_ack = 1'b0;
	logic               sda_in = 1'b1;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               scl_low;
	logic               sda_low;
	logic               busy_res;
	logic               done_res;
	logic [7:0]         read_data;
	logic               ack_seen;
	logic               rejected;

	i2c_master_byte_controller uut (.*);

	// predicted controller state
	phase_t          ph = PH_IDLE;
	kind_t           kind = KIND_START;
	logic [3:0]      bidx = '0;
	int              wait_left = 0;
	logic [7:0]      sreg = '0;
	logic [7:0]      rd_latch = '0;
	logic            scl_d = 1'b0;
	logic            sda_d = 1'b0;
	logic            ack_rx = 1'b0;
	logic            ack_tx = 1'b0;
	logic [HP_W-1:0] hp_reg = HALF_PERIOD_RST;

	bus_view_t pin_q[$];
	int        fail_count = 0;
	int        words_sent = 0;
	int        cycle_count = 0;
	int        send_idle_pct = 0;
	int        stall_pct = 0;

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic report_mismatch(string what, int got, int want);
		fail_count++;
		if (fail_count <= 40)
			$display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
	endtask

	always @(posedge clk) begin
		bus_view_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pin_q.size() == 0) begin
				report_mismatch("result word with none expected", 0, 0);
			end else begin
				want = pin_q.pop_front();
				if (scl_low !== want.scl) report_mismatch("scl_low", scl_low, want.scl);
				if (sda_low !== want.sda) report_mismatch("sda_low", sda_low, want.sda);
				if (busy_res !== want.busy) report_mismatch("busy_res", busy_res, want.busy);
				if (done_res !== want.done) report_mismatch("done_res", done_res, want.done);
				if (read_data !== want.rdata)
					report_mismatch("read_data", read_data, want.rdata);
				if (ack_seen !== want.ack) report_mismatch("ack_seen", ack_seen, want.ack);
				if (rejected !== want.rej) report_mismatch("rejected", rejected, want.rej);
			end
		end
	end

	function automatic int half_load();
		int h;
		h = int'(hp_reg);
		if (h == 0) h = 1;
		if (h > CNT_MAX) h = CNT_MAX;
		return h;
	endfunction

	// data MSB on a write, the ACK/NACK level on a read
	function automatic logic tx_bit();
		return (kind == KIND_READ) ? !ack_tx : sreg[7];
	endfunction

	function automatic void enter_phase(phase_t p);
		ph = p;
		case (p)
			PH_START_A: begin
				scl_d = 1'b0;
				sda_d = 1'b0;
			end
			PH_START_B: sda_d = 1'b1;
			PH_START_C: scl_d = 1'b1;
			PH_STOP_A: begin
				scl_d = 1'b1;
				sda_d = 1'b1;
			end
			PH_STOP_B: scl_d = 1'b0;
			PH_STOP_C: sda_d = 1'b0;
			PH_WBIT_HIGH: begin
				sda_d = !tx_bit();
				scl_d = 1'b0;
			end
			PH_WBIT_LOW, PH_RBIT_LOW: scl_d = 1'b1;
			PH_RBIT_HIGH: begin
				sda_d = 1'b0;
				scl_d = 1'b0;
			end
			default: ;
		endcase
		wait_left = half_load();
	endfunction

	// returns 1 when the command completes
	function automatic logic finish_phase(logic sda);
		case (ph)
			PH_START_A: begin
				enter_phase(PH_START_B);
				return 1'b0;
			end
			PH_START_B: begin
				enter_phase(PH_START_C);
				return 1'b0;
			end
			PH_STOP_A: begin
				enter_phase(PH_STOP_B);
				return 1'b0;
			end
			PH_STOP_B: begin
				enter_phase(PH_STOP_C);
				return 1'b0;
			end
			PH_WBIT_HIGH: begin
				enter_phase(PH_WBIT_LOW);
				return 1'b0;
			end
			PH_WBIT_LOW: begin
				// a 1 bit pulls SDA low again before the next phase
				if (tx_bit()) sda_d = 1'b1;
				if (kind == KIND_READ) begin
					enter_phase(PH_READ_TAIL);
					return 1'b0;
				end
				sreg = sreg << 1;
				bidx = bidx + 4'd1;
				if (bidx < BITS_PER_BYTE) enter_phase(PH_WBIT_HIGH);
				else enter_phase(PH_RBIT_HIGH);
				return 1'b0;
			end
			PH_RBIT_HIGH: begin
				if (kind == KIND_READ) sreg = {sreg[6:0], sda};
				else ack_rx = sda;
				enter_phase(PH_RBIT_LOW);
				return 1'b0;
			end
			PH_RBIT_LOW: begin
				if (kind == KIND_READ) begin
					bidx = bidx + 4'd1;
					if (bidx < BITS_PER_BYTE) enter_phase(PH_RBIT_HIGH);
					else enter_phase(PH_WBIT_HIGH);
					return 1'b0;
				end
			end
			PH_READ_TAIL: rd_latch = sreg;
			default: ;
		endcase
		ph = PH_IDLE;
		wait_left = 0;
		return 1'b1;
	endfunction

	function automatic void advance_bus(logic [2:0] act, logic [7:0] b, logic sack, logic sda);
		logic done, rej;
		done = 1'b0;
		rej = 1'b0;
		if (act == ACT_TICK) begin
			if (ph != PH_IDLE) begin
				if (wait_left > 1) wait_left--;
				else done = finish_phase(sda);
			end
		end else if (act <= ACT_READ) begin
			if (ph != PH_IDLE) begin
				rej = 1'b1;
			end else begin
				bidx = '0;
				case (act)
					ACT_START: begin
						kind = KIND_START;
						enter_phase(PH_START_A);
					end
					ACT_STOP: begin
						kind = KIND_STOP;
						enter_phase(PH_STOP_A);
					end
					ACT_WRITE: begin
						kind = KIND_WRITE;
						sreg = b;
						enter_phase(PH_WBIT_HIGH);
					end
					default: begin
						kind = KIND_READ;
						sreg = '0;
						ack_tx = sack;
						enter_phase(PH_RBIT_HIGH);
					end
				endcase
			end
		end
		pin_q.push_back('{scl: scl_d, sda: sda_d, busy: (ph != PH_IDLE), done: done,
			rdata: rd_latch, ack: ack_rx, rej: rej});
	endfunction

	task automatic send_word(logic [2:0] act, logic [7:0] b, logic sack, logic sda);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		byte_out <= b;
		send_ack <= sack;
		sda_in <= sda;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		advance_bus(act, b, sack, sda);
		words_sent++;
	endtask

	// sda_sel 0 or 1 holds the line level, above 1 randomizes it
	task automatic tick_until_idle(int sda_sel);
		logic sda;
		while (ph != PH_IDLE) begin
			sda = (sda_sel > 1) ? 1'($urandom) : 1'(sda_sel);
			send_word(ACT_TICK, 8'($urandom), 1'($urandom), sda);
		end
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		while (pin_q.size() != 0) @(posedge clk);
	endtask

	task automatic settle_bus();
		tick_until_idle(2);
		wait_results();
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_access(logic wr, logic [PADDR_W-3:0] idx, logic [PDATA_W-1:0] wdata,
			output logic [PDATA_W-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_half_period();
		logic [PDATA_W-1:0] rd;
		apb_access(1'b0, REG_HALF_PERIOD, '0, rd);
		if (rd[HP_W-1:0] !== hp_reg) report_mismatch("half_period_ticks", rd[HP_W-1:0], hp_reg);
	endtask

	task automatic set_half_period(int v);
		logic [PDATA_W-1:0] rd;
		settle_bus();
		apb_access(1'b1, REG_HALF_PERIOD, PDATA_W'(v), rd);
		hp_reg = HP_W'(v);
		check_half_period();
	endtask

	// given command followed by ticks, with the odd command thrown in while busy
	task automatic run_command(logic [2:0] act);
		send_word(act, 8'($urandom), 1'($urandom), 1'($urandom));
		while (ph != PH_IDLE) begin
			if ($urandom_range(99) < 4)
				send_word(3'($urandom_range(7, 1)), 8'($urandom), 1'($urandom), 1'($urandom));
			else
				send_word(ACT_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
		end
	endtask

	task automatic test_reset_state();
		check_half_period();
		send_word(ACT_TICK, 8'h00, 1'b0, 1'b0);
		send_word(ACT_TICK, 8'hFF, 1'b1, 1'b1);
		for (int c = int'(ACT_READ) + 1; c < 8; c++)
			send_word(3'(c), 8'($urandom), 1'($urandom), 1'($urandom));
		send_word(ACT_START, 8'h00, 1'b0, 1'b1);
		tick_until_idle(2);
		wait_results();
	endtask

	task automatic test_register_port();
		logic [PDATA_W-1:0] rd;
		settle_bus();
		apb_access(1'b1, REG_SPARE, '1, rd);
		check_half_period();
		set_half_period(0);
		send_word(ACT_START, 8'h00, 1'b0, 1'b0);
		tick_until_idle(0);
	endtask

	task automatic test_directed_commands();
		set_half_period(1);
		send_word(ACT_START, 8'h00, 1'b0, 1'b1);
		send_word(ACT_TICK, 8'h00, 1'b0, 1'b1);
		send_word(ACT_STOP, 8'h00, 1'b0, 1'b1);
		send_word(ACT_WRITE, 8'hFF, 1'b1, 1'b0);
		send_word(ACT_READ, 8'h00, 1'b1, 1'b0);
		send_word(3'(int'(ACT_READ) + 3), 8'hFF, 1'b0, 1'b1);
		tick_until_idle(1);
		send_word(ACT_WRITE, 8'hFF, 1'b0, 1'b1);
		tick_until_idle(0);
		send_word(ACT_WRITE, 8'h00, 1'b1, 1'b0);
		tick_until_idle(1);
		send_word(ACT_READ, 8'h00, 1'b1, 1'b1);
		tick_until_idle(1);
		// NACK keeps SDA low through the tail half period
		send_word(ACT_READ, 8'hFF, 1'b0, 1'b0);
		tick_until_idle(0);
		send_word(ACT_STOP, 8'h5A, 1'b0, 1'b1);
		tick_until_idle(2);
	endtask

	// one full half period at the top count, then the rest of the command at a short one
	task automatic test_longest_half_period();
		logic [PDATA_W-1:0] rd;
		send_idle_pct = 0;
		stall_pct = 0;
		set_half_period(CNT_MAX);
		send_word(ACT_STOP, 8'h00, 1'b0, 1'b1);
		while (wait_left > 1)
			send_word(ACT_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
		wait_results();
		apb_access(1'b1, REG_HALF_PERIOD, PDATA_W'(1), rd);
		hp_reg = HP_W'(1);
		tick_until_idle(2);
	endtask

	task automatic test_random_traffic(int idle_pct, int hold_pct, int hp, int n);
		int base, ignored, r;
		send_idle_pct = idle_pct;
		stall_pct = hold_pct;
		set_half_period(hp);
		base = words_sent;
		ignored = 0;
		while (words_sent - base - ignored < n) begin
			r = $urandom_range(99);
			if (r < 10) begin
				// idle ticks and unused codes change nothing
				send_word((r < 5) ? ACT_TICK : 3'($urandom_range(7, int'(ACT_READ) + 1)),
					8'($urandom), 1'($urandom), 1'($urandom));
				ignored++;
			end else begin
				run_command(3'($urandom_range(int'(ACT_READ), int'(ACT_START))));
			end
		end
	endtask

	task automatic test_drain_pause();
		send_idle_pct = 17;
		stall_pct = 17;
		set_half_period(2);
		repeat (3) run_command(3'($urandom_range(int'(ACT_READ), int'(ACT_START))));
		wait_results();
		repeat (3) run_command(3'($urandom_range(int'(ACT_READ), int'(ACT_START))));
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_register_port();
		test_directed_commands();
		test_longest_half_period();
		test_random_traffic(0, 0, 1, 200);
		test_random_traffic(87, 0, 2, 150);
		test_random_traffic(0, 87, 3, 150);
		test_random_traffic(17, 17, 0, 150);
		test_drain_pause();
		settle_bus();
		if (fail_count == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/i2cmbc_pkg.sv
hw/rtl/i2cmbc_step.sv
hw/rtl/i2c_master_byte_controller.sv
dv/i2c_master_byte_controller_tb.sv
